/* rtl/mtd_pkg.sv */
// Shared types, character codes and the Morse pattern lookup for the Morse text decoder.
package mtd_pkg;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_QMARK = 8'h3F;

	localparam logic [2:0] MAX_SYMBOLS = 3'd6;
	localparam logic [2:0] LEN_SAT     = 3'd7;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} mtd_result_t;

	typedef struct packed {
		logic [1:0]  count;
		mtd_result_t first;
		mtd_result_t second;
	} mtd_push_t;

	// Pattern holds the oldest symbol in the highest used bit; a one is a dash.
	function automatic logic [7:0] mtd_decode(input logic [2:0] len, input logic [5:0] pat,
		input logic bad);
		logic [7:0] ch;
		ch = CH_QMARK;
		if (!bad && len <= MAX_SYMBOLS) begin
			unique case ({len, pat})
				{3'd2, 6'h01}: ch = "A";
				{3'd4, 6'h08}: ch = "B";
				{3'd4, 6'h0A}: ch = "C";
				{3'd3, 6'h04}: ch = "D";
				{3'd1, 6'h00}: ch = "E";
				{3'd4, 6'h02}: ch = "F";
				{3'd3, 6'h06}: ch = "G";
				{3'd4, 6'h00}: ch = "H";
				{3'd2, 6'h00}: ch = "I";
				{3'd4, 6'h07}: ch = "J";
				{3'd3, 6'h05}: ch = "K";
				{3'd4, 6'h04}: ch = "L";
				{3'd2, 6'h03}: ch = "M";
				{3'd2, 6'h02}: ch = "N";
				{3'd3, 6'h07}: ch = "O";
				{3'd4, 6'h06}: ch = "P";
				{3'd4, 6'h0D}: ch = "Q";
				{3'd3, 6'h02}: ch = "R";
				{3'd3, 6'h00}: ch = "S";
				{3'd1, 6'h01}: ch = "T";
				{3'd3, 6'h01}: ch = "U";
				{3'd4, 6'h01}: ch = "V";
				{3'd3, 6'h03}: ch = "W";
				{3'd4, 6'h09}: ch = "X";
				{3'd4, 6'h0B}: ch = "Y";
				{3'd4, 6'h0C}: ch = "Z";
				{3'd5, 6'h0F}: ch = "1";
				{3'd5, 6'h07}: ch = "2";
				{3'd5, 6'h03}: ch = "3";
				{3'd5, 6'h01}: ch = "4";
				{3'd5, 6'h00}: ch = "5";
				{3'd5, 6'h10}: ch = "6";
				{3'd5, 6'h18}: ch = "7";
				{3'd5, 6'h1C}: ch = "8";
				{3'd5, 6'h1E}: ch = "9";
				{3'd5, 6'h1F}: ch = "0";
				{3'd6, 6'h0D}: ch = "_";
				default:       ch = CH_QMARK;
			endcase
		end
		return ch;
	endfunction

endpackage

/* rtl/mtd_result_fifo.sv */
// Four-entry result queue that takes up to two results per cycle and sends one beat per cycle while tready is high.
module mtd_result_fifo
	import mtd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  mtd_push_t  push,
	output logic       room,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // decoded_char[7:0]
	output logic       m_axis_tlast   // run_last
);

	mtd_result_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;
	logic                 pop;

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign room          = count_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
	assign m_axis_tvalid = count_q != '0;
	assign m_axis_tdata  = mem_q[rd_ptr_q].ch;
	assign m_axis_tlast  = mem_q[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + FIFO_AW'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.count);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			count_q  <= count_q + (FIFO_AW + 1)'(push.count) - (FIFO_AW + 1)'(pop);
		end
	end

endmodule

/* rtl/morse_text_decoder_top.sv */
// Top level of the Morse text decoder: input register, group state, decode and result queue.
//
//  Channel   Role    tdata             tlast         Beats
//  s_axis    in      symbol_char[7:0]  message_end   one Morse text character
//  m_axis    out     decoded_char[7:0] run_last      zero, one or two per input beat
//
// An input beat is registered in the input stage, then decoded and written into the result
// queue. One input beat is taken every cycle while the four-entry result queue has room for
// two results. Reset clears the group, the input stage and the queue. A stalled output holds
// results in the queue, and input stalls once fewer than two queue entries are free.
module morse_text_decoder_top
	import mtd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // symbol_char[7:0]
	input  logic       s_axis_tlast,  // message_end
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // decoded_char[7:0]
	output logic       m_axis_tlast   // run_last
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;

	logic [5:0] pat_q;
	logic [2:0] len_q;
	logic       bad_q;

	logic       room;
	logic       advance;
	logic       is_space;
	logic       is_slash;
	logic       is_dot;
	logic       is_dash;
	logic [5:0] new_pat;
	logic [2:0] new_len;
	logic       new_bad;
	logic [7:0] cur_code;
	logic [7:0] new_code;
	logic       clear_group;
	mtd_push_t  push;

	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	assign is_space = char_s1 == CH_SPACE;
	assign is_slash = char_s1 == CH_SLASH;
	assign is_dot   = char_s1 == CH_DOT;
	assign is_dash  = char_s1 == CH_DASH;

	assign new_pat  = (len_q < MAX_SYMBOLS) ? {pat_q[4:0], is_dash} : pat_q;
	assign new_len  = (len_q < LEN_SAT) ? len_q + 3'd1 : len_q;
	assign new_bad  = bad_q || !(is_dot || is_dash);
	assign cur_code = mtd_decode(len_q, pat_q, bad_q);
	assign new_code = mtd_decode(new_len, new_pat, new_bad);

	assign clear_group = is_space || is_slash || end_s1;

	always_comb begin
		push = '0;
		if (advance) begin
			if (is_space) begin
				if (len_q != 3'd0) begin
					push.count = 2'd1;
					push.first = '{ch: cur_code, last: 1'b1};
				end
			end else if (is_slash) begin
				if (len_q != 3'd0) begin
					push.count  = 2'd2;
					push.first  = '{ch: cur_code, last: 1'b0};
					push.second = '{ch: CH_SPACE, last: 1'b1};
				end else begin
					push.count = 2'd1;
					push.first = '{ch: CH_SPACE, last: 1'b1};
				end
			end else if (end_s1) begin
				push.count = 2'd1;
				push.first = '{ch: new_code, last: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			len_q <= '0;
			bad_q <= 1'b0;
		end else if (advance) begin
			if (clear_group) begin
				pat_q <= '0;
				len_q <= '0;
				bad_q <= 1'b0;
			end else begin
				pat_q <= new_pat;
				len_q <= new_len;
				bad_q <= new_bad;
			end
		end
	end

	mtd_result_fifo u_result_fifo (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.room          (room),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_empty_group_clean: assert property (@(posedge clk) disable iff (!arst_n)
		len_q == 3'd0 |-> (pat_q == 6'd0 && !bad_q))
		else $error("Empty group carries pattern or bad mark.");

	a_pattern_fits: assert property (@(posedge clk) disable iff (!arst_n)
		len_q < MAX_SYMBOLS |-> (pat_q >> len_q) == 6'd0)
		else $error("Group pattern has bits above its length.");

	a_separator_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && clear_group |=> len_q == 3'd0)
		else $error("Group not cleared after a separator or message end.");

	a_pair_ends_in_space: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> (push.second.ch == CH_SPACE && is_slash))
		else $error("Second result of a beat is not a word gap.");

endmodule
